FILE: hdl/dqd_pkg.sv
// ----------------------------------------------------------------------------
// dqd_pkg: shared types and constants for the double-ended queue
// Command codes, status codes, transfer payload structs and the control
// bundle that the top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package dqd_pkg;

  // Store geometry
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths of the transfer payloads
  localparam int CMD_W  = 2;
  localparam int ITEM_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_PREPEND = 2'd1,
    CMD_DEQUEUE = 2'd2,
    CMD_DELETE  = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ITEM_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ITEM_W-1:0] item_out;
    logic [LEN_W-1:0]  length;
  } out_item_t;

  // Broadcast to all cells for one transfer
  typedef struct packed {
    logic              push_tail;  // write key into the cell at the tail
    logic              load_head;  // every cell takes its left neighbor
    logic              pop_head;   // every cell takes its right neighbor
    logic              del_arm;    // cells at or after the match take right
    logic [DATA_W-1:0] key;
  } cell_ctrl_t;

endpackage

FILE: hdl/dqd_cell.sv
// ----------------------------------------------------------------------------
// dqd_cell: one storage cell of the queue
// Holds one handle, compares it against the broadcast key and loads from
// its left or right neighbor, or from the key, as the command requires.
// ----------------------------------------------------------------------------
module dqd_cell (
  input  logic                     clk,
  input  dqd_pkg::cell_ctrl_t      ctrl,
  input  logic                     occupied,
  input  logic                     is_tail,
  input  logic [dqd_pkg::DATA_W-1:0] left_data,
  input  logic [dqd_pkg::DATA_W-1:0] right_data,
  input  logic                     hit_in,
  output logic [dqd_pkg::DATA_W-1:0] data,
  output logic                     hit_out
);
  import dqd_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              match;

  // Flag a match only on a held entry; pass the first-match mark down the row
  assign match   = occupied && (data_r == ctrl.key);
  assign hit_out = hit_in || match;

  // Select the next value: shift toward head, shift toward tail, or load key
  always_comb begin
    data_nxt = data_r;
    if (ctrl.push_tail && is_tail) begin
      data_nxt = ctrl.key;
    end else if (ctrl.load_head) begin
      data_nxt = left_data;
    end else if (ctrl.pop_head) begin
      data_nxt = right_data;
    end else if (ctrl.del_arm && hit_out) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

FILE: hdl/deque_with_delete_by_value_unit.sv
// ----------------------------------------------------------------------------
// deque_with_delete_by_value_unit: bounded deque with delete by value
// Append, prepend, dequeue and delete-first-match on a row of cells.
// ----------------------------------------------------------------------------
// For each command, every cell compares its handle with the key and loads
// from a neighbor in the same clock edge, so an item is accepted
// every cycle as long as the result register is free or being drained. The
// result appears in the output register the cycle after acceptance. The
// delete search ripples a first-match mark across all DEPTH cells, which
// sets the critical path. There is no clearing pass after reset.
module deque_with_delete_by_value_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dqd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dqd_pkg::out_item_t  out_data
);
  import dqd_pkg::*;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_item_t         out_data_r;
  out_item_t         out_data_nxt;

  logic              fire;
  logic              full;
  logic              empty;
  logic              found;
  cmd_t              cmd;
  cell_ctrl_t        ctrl;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] left_chain [DEPTH];
  logic [DATA_W-1:0] right_chain [DEPTH];
  logic [DEPTH:0]    hit_chain;

  // Accept while the result register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign cmd      = cmd_t'(in_data.command);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign found    = hit_chain[DEPTH];

  // Broadcast control to the row; without a match no cell sees a hit
  always_comb begin
    ctrl.key       = DATA_W'(in_data.item_value);
    ctrl.push_tail = fire && (cmd == CMD_APPEND) && !full;
    ctrl.load_head = fire && (cmd == CMD_PREPEND) && !full;
    ctrl.pop_head  = fire && (cmd == CMD_DEQUEUE) && !empty;
    ctrl.del_arm   = fire && (cmd == CMD_DELETE);
  end

  // Row of cells; the key enters at the head, the last cell reloads itself
  assign hit_chain[0] = 1'b0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_chain[i] = ctrl.key;
    end else begin : g_mid
      assign left_chain[i] = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_chain[i] = cell_data[i];
    end else begin : g_inner
      assign right_chain[i] = cell_data[i+1];
    end

    dqd_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CNT_W'(i) < count_r),
      .is_tail    (CNT_W'(i) == count_r),
      .left_data  (left_chain[i]),
      .right_data (right_chain[i]),
      .hit_in     (hit_chain[i]),
      .data       (cell_data[i]),
      .hit_out    (hit_chain[i+1])
    );
  end

  // Fill count and result for the accepted transfer
  always_comb begin
    count_nxt             = count_r;
    out_data_nxt          = out_data_r;
    out_valid_nxt         = out_valid_r && !out_ready;
    if (fire) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.status   = ST_OK;
      out_data_nxt.item_out = '0;
      case (cmd)
        CMD_APPEND, CMD_PREPEND: begin
          if (full) begin
            out_data_nxt.status = ST_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_DEQUEUE: begin
          if (empty) begin
            out_data_nxt.status = ST_EMPTY;
          end else begin
            count_nxt             = count_r - 1'b1;
            out_data_nxt.item_out = ITEM_W'(cell_data[0]);
          end
        end
        CMD_DELETE: begin
          if (found) begin
            count_nxt = count_r - 1'b1;
          end else begin
            out_data_nxt.status = ST_EMPTY;
          end
        end
        default: begin
          out_data_nxt.status = ST_EMPTY;
        end
      endcase
      out_data_nxt.length = LEN_W'(count_nxt);
    end
  end

  // Clear control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
